>>> hw/rtl/rft_pkg.sv
`default_nettype none
package rft_pkg;

    // message byte and configuration widths
    localparam int SYM_W          = 8;
    localparam int RAILS_W        = 7;
    localparam int POS_W          = 8;   // holds a position plus one full zigzag stride
    localparam int MAX_MESSAGE_DEF = 64;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_RAILS     = 1'd0;
    localparam t_cfg_idx REG_DIRECTION = 1'd1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

endpackage
`default_nettype wire

>>> hw/rtl/rft_if.sv
`default_nettype none

interface rft_in_if import rft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             final_symbol;

    modport source (output valid, output symbol, output final_symbol, input ready);
    modport sink   (input valid, input symbol, input final_symbol, output ready);
endinterface

interface rft_out_if import rft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_symbol;
    logic             out_final;
    logic             truncated;

    modport source (output valid, output out_symbol, output out_final, output truncated,
                    input ready);
    modport sink   (input valid, input out_symbol, input out_final, input truncated,
                    output ready);
endinterface

interface rft_cfg_if import rft_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rail_fence_transposer_unit.sv
`default_nettype none
// Rail fence transposer. Message bytes are taken one per cycle into a buffer of
// MAX_MESSAGE entries until a beat flagged final_symbol; bytes past capacity are dropped
// and every output beat of that message then carries truncated. After the final beat
// the block stops taking input and emits the message permuted by the zigzag rule with
// the configured number of rails (zero or one rail passes data through). Encryption
// walks the zigzag rail by rail and emits straight from the load buffer. Decryption
// first scatters the buffer into a second buffer along the same walk and then emits
// that buffer in order. Each byte is emitted through a registered buffer read and
// then the output register, and emission holds while that register is full and not
// drained. The zigzag walk uses one shared adder that steps the position by the
// current rail's stride. Configuration is accepted at any time but must only change
// while no message is in flight.
module rail_fence_transposer_unit
    import rft_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    rft_in_if.sink         i_in,
    rft_out_if.source      o_out,
    rft_cfg_if.sink        i_cfg
);

    localparam int AW     = $clog2(MAX_MESSAGE);
    localparam int FILL_W = $clog2(MAX_MESSAGE + 1);

    // sequencer states
    localparam logic [1:0] S_LOAD = 2'd0;  // collecting message bytes
    localparam logic [1:0] S_SCAN = 2'd1;  // decrypt: scatter along the zigzag
    localparam logic [1:0] S_RD   = 2'd2;  // issue a buffer read for the next byte
    localparam logic [1:0] S_WR   = 2'd3;  // move read data into the output register

    logic [1:0]         r_state, n_state;

    // configuration
    logic [RAILS_W-1:0] r_rails;
    logic               r_dir;

    // message bookkeeping
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_ovf, n_ovf;
    logic [FILL_W-1:0]  r_k, n_k;         // beat count during scan and emission
    logic               r_last, n_last;

    // zigzag walker
    logic [AW-1:0]      r_row, n_row;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_phase, n_phase;

    // buffers
    logic [SYM_W-1:0]   r_load_mem [MAX_MESSAGE];
    logic [SYM_W-1:0]   r_perm_mem [MAX_MESSAGE];
    logic [SYM_W-1:0]   r_load_rdata;
    logic [SYM_W-1:0]   r_perm_rdata;
    logic [AW-1:0]      r_wpos;
    logic               r_wvalid, n_wvalid;

    // output register
    logic               r_out_valid;
    logic [SYM_W-1:0]   r_out_symbol;
    logic               r_out_final;
    logic               r_out_trunc;

    logic               w_in_acc;
    logic               w_full;
    logic               w_out_load;
    logic               w_step;
    logic               w_load_rd;
    logic [AW-1:0]      w_load_raddr;
    logic               w_perm_rd;

    logic [RAILS_W-1:0] w_nr;
    logic [POS_W-1:0]   w_cyc;
    logic [POS_W-1:0]   w_two_row;
    logic [POS_W-1:0]   w_str_a;
    logic [POS_W-1:0]   w_stride;
    logic [POS_W-1:0]   w_next_pos;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign i_in.ready       = (r_state == S_LOAD);
    assign w_in_acc         = i_in.valid && i_in.ready;
    assign i_cfg.ready      = 1'b1;
    assign w_full           = (r_fill == FILL_W'(MAX_MESSAGE));

    assign o_out.valid      = r_out_valid;
    assign o_out.out_symbol = r_out_symbol;
    assign o_out.out_final  = r_out_final;
    assign o_out.truncated  = r_out_trunc;

    // output register can take a byte when empty or being drained this cycle
    assign w_out_load = (r_state == S_WR) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rails <= RAILS_W'(2);
            r_dir   <= DIR_ENCRYPT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_RAILS:     r_rails <= i_cfg.data[RAILS_W-1:0];
                REG_DIRECTION: r_dir   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // zigzag stride: rail r alternates cyc-2r and 2r, a zero stride
    // takes the other one, a single rail steps by one
    // ---------------------------------------------------------------
    assign w_nr       = (r_rails == '0) ? RAILS_W'(1) : r_rails;
    assign w_cyc      = POS_W'({w_nr - RAILS_W'(1), 1'b0});
    assign w_two_row  = POS_W'({r_row, 1'b0});
    assign w_str_a    = w_cyc - w_two_row;

    always_comb begin
        if (w_nr == RAILS_W'(1)) begin
            w_stride = POS_W'(1);
        end else if (!r_phase) begin
            w_stride = (w_str_a != '0) ? w_str_a : w_two_row;
        end else begin
            w_stride = (w_two_row != '0) ? w_two_row : w_str_a;
        end
    end

    // the shared adder
    assign w_next_pos = r_pos + w_stride;

    // walker advances when encrypt emits or decrypt scatters a byte
    assign w_step = ((r_state == S_RD) && (r_dir == DIR_ENCRYPT))
                 || ((r_state == S_SCAN) && (r_k != r_fill));

    assign w_load_rd    = w_step;
    assign w_load_raddr = (r_state == S_SCAN) ? r_k[AW-1:0] : r_pos[AW-1:0];
    assign w_perm_rd    = (r_state == S_RD) && (r_dir == DIR_DECRYPT);

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_ovf    = r_ovf;
        n_k      = r_k;
        n_last   = r_last;
        n_row    = r_row;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_wvalid = 1'b0;

        // walker step; the next rail always starts inside the message
        if (w_step) begin
            if (w_next_pos < POS_W'(r_fill)) begin
                n_pos   = w_next_pos;
                n_phase = !r_phase;
            end else begin
                n_row   = r_row + AW'(1);
                n_pos   = POS_W'(r_row) + POS_W'(1);
                n_phase = 1'b0;
            end
        end

        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (!w_full) begin
                        n_fill = r_fill + FILL_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.final_symbol) begin
                        n_k     = '0;
                        n_row   = '0;
                        n_pos   = '0;
                        n_phase = 1'b0;
                        n_state = (r_dir == DIR_DECRYPT) ? S_SCAN : S_RD;
                    end
                end
            end
            S_SCAN: begin
                if (r_k != r_fill) begin
                    n_k      = r_k + FILL_W'(1);
                    n_wvalid = 1'b1;
                end else begin
                    // last scatter write lands at this edge
                    n_k     = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_last  = (r_k + FILL_W'(1) == r_fill);
                n_k     = r_k + FILL_W'(1);
                n_state = S_WR;
            end
            S_WR: begin
                if (w_out_load) begin
                    if (r_last) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_k         <= '0;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovf    <= n_ovf;
            r_k      <= n_k;
            r_wvalid <= n_wvalid;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_row   <= n_row;
        r_pos   <= n_pos;
        r_phase <= n_phase;
        if (w_step) begin
            r_wpos <= r_pos[AW-1:0];
        end
        if (w_out_load) begin
            r_out_symbol <= (r_dir == DIR_ENCRYPT) ? r_load_rdata : r_perm_rdata;
            r_out_final  <= r_last;
            r_out_trunc  <= r_ovf;
        end
    end

    // ---------------------------------------------------------------
    // buffers: one write and one registered read each
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_full) begin
            r_load_mem[r_fill[AW-1:0]] <= i_in.symbol;
        end
        if (w_load_rd) begin
            r_load_rdata <= r_load_mem[w_load_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wvalid) begin
            r_perm_mem[r_wpos] <= r_load_rdata;
        end
        if (w_perm_rd) begin
            r_perm_rdata <= r_perm_mem[r_k[AW-1:0]];
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_MESSAGE))
        else $error("fill count beyond buffer capacity");

    a_final_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.final_symbol) |=> (r_state != S_LOAD))
        else $error("final beat did not start emission");

    a_walk_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (r_pos < POS_W'(r_fill)))
        else $error("zigzag walk left the message");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_k <= r_fill))
        else $error("beat count beyond message length");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_last) |=> (r_state == S_LOAD && r_fill == '0))
        else $error("message end did not return to loading");
`endif

endmodule
`default_nettype wire

>>> tb/rft_permutation_check.sv
`timescale 1ns / 100ps

module rft_permutation_check
    import rft_pkg::*;
#(
    parameter int MAX_MESSAGE = MAX_MESSAGE_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rft_in_if    i_in,
    rft_out_if   i_out,
    rft_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_final;
        logic             truncated;
    } t_out_beat;

    t_out_beat              expected_beats[$];
    logic [SYM_W-1:0]       msg_buf [MAX_MESSAGE];
    int                     fill_level;
    bit                     overflowed;
    logic [RAILS_W-1:0]     rails_cfg;
    logic                   dir_cfg;
    int                     out_beat_idx;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        out_beat_idx = 0;
    end

    // rail that a plain position sits on in the zigzag
    function automatic int zigzag_row(int pos, int nr);
        int period;
        int m;
        if (nr <= 1) return 0;
        period = 2 * (nr - 1);
        m      = pos % period;
        return (m < nr) ? m : period - m;
    endfunction

    task automatic queue_permuted();
        logic [SYM_W-1:0] permuted [MAX_MESSAGE];
        t_out_beat        beat;
        int               nr;
        int               k;
        nr = (rails_cfg == '0) ? 1 : int'(rails_cfg);
        k  = 0;
        for (int row = 0; row < nr && k < fill_level; row++) begin
            for (int p = 0; p < fill_level; p++) begin
                if (zigzag_row(p, nr) == row) begin
                    if (dir_cfg == DIR_ENCRYPT) permuted[k] = msg_buf[p];
                    else                        permuted[p] = msg_buf[k];
                    k++;
                end
            end
        end
        for (int j = 0; j < fill_level; j++) begin
            beat.symbol    = permuted[j];
            beat.is_final  = (j == fill_level - 1);
            beat.truncated = overflowed;
            expected_beats.insert(expected_beats.size(), beat);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            expected_beats.delete();
            fill_level = 0;
            overflowed = 1'b0;
            rails_cfg  = RAILS_W'(2);
            dir_cfg    = DIR_ENCRYPT;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_RAILS:     rails_cfg = i_cfg.data[RAILS_W-1:0];
                    REG_DIRECTION: dir_cfg   = i_cfg.data[0];
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                if (fill_level < MAX_MESSAGE) begin
                    msg_buf[fill_level] = i_in.symbol;
                    fill_level++;
                end else begin
                    overflowed = 1'b1;
                end
                if (i_in.final_symbol) begin
                    queue_permuted();
                    fill_level = 0;
                    overflowed = 1'b0;
                end
            end

            if (i_out.valid && i_out.ready) begin
                if (expected_beats.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display({"rft check: output beat %0d with nothing expected: ",
                                  "sym %02h final %0b trunc %0b"},
                                 out_beat_idx, i_out.out_symbol, i_out.out_final,
                                 i_out.truncated);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out.out_symbol !== want.symbol || i_out.out_final !== want.is_final ||
                        i_out.truncated !== want.truncated) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"rft check: beat %0d expected sym %02h final %0b ",
                                      "trunc %0b, got sym %02h final %0b trunc %0b"},
                                     out_beat_idx, want.symbol, want.is_final,
                                     want.truncated, i_out.out_symbol, i_out.out_final,
                                     i_out.truncated);
                    end
                end
                out_beat_idx++;
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench import rft_pkg::*; ();

    // no beat moves for this many cycles means the block is hung; the worst honest gap
    // is the long receiver hold-off below plus a message drain, far under this
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;   // long receiver stall that backs up the input
    localparam int SETTLE_CYCLES  = 8;     // block returns to idle after its last beat
    localparam int TAIL_CYCLES    = 40;    // quiet time at the end to catch stray beats
    localparam int ITEM_TARGET    = 270;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rft_in_if  in_bus ();
    rft_out_if out_bus ();
    rft_cfg_if cfg_bus ();

    int fail_count;
    int pending;

    // knobs shared by the stimulus and the receiver
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    rail_fence_transposer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    rft_permutation_check perm_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_bus),
        .i_out        (out_bus),
        .i_cfg        (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request counted here
    initial begin : recv_side
        int hold_left;
        hold_left     = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // hang detection: counts cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat; called and returning at a falling edge, leaves valid up
    task automatic send_byte(logic [SYM_W-1:0] sym, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.symbol       <= sym;
        in_bus.final_symbol <= fin;
        do @(posedge i_clk); while (!in_bus.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_message(int len);
        for (int i = 0; i < len; i++)
            send_byte(SYM_W'($urandom_range(255)), i == len - 1);
    endtask

    // one config beat; same edge discipline as send_byte
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        @(negedge i_clk);
    endtask

    // both registers, with junk in the unused direction bits
    task automatic set_config(logic [RAILS_W-1:0] nrails, logic dir);
        write_reg(REG_RAILS, CFG_DATA_W'(nrails));
        write_reg(REG_DIRECTION, {(CFG_DATA_W-1)'($urandom_range(63)), dir});
        cfg_bus.valid <= 1'b0;
    endtask

    // sender pauses until every expected beat is out and the block has gone idle
    task automatic settle_idle();
        in_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idle_mode(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
    endtask

    initial begin : stimulus
        int                 phase;
        int                 roll;
        int                 len;
        logic [RAILS_W-1:0] nrails;

        in_bus.valid        = 1'b0;
        in_bus.symbol       = '0;
        in_bus.final_symbol = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = REG_RAILS;
        cfg_bus.data        = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, two rails encrypting, byte extremes
        set_idle_mode(0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b1);
        settle_idle();

        // zero rails acts as one rail: pass through
        set_config(RAILS_W'(0), DIR_ENCRYPT);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        settle_idle();

        // one rail decrypting is also pass through
        set_config(RAILS_W'(1), DIR_DECRYPT);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        settle_idle();

        // three rails both ways on the same text
        set_config(RAILS_W'(3), DIR_ENCRYPT);
        for (int i = 0; i < 6; i++) send_byte(SYM_W'(8'h10 + i), i == 5);
        settle_idle();
        set_config(RAILS_W'(3), DIR_DECRYPT);
        for (int i = 0; i < 6; i++) send_byte(SYM_W'(8'h10 + i), i == 5);
        settle_idle();

        // rails far beyond the message length, largest register value
        set_config(RAILS_W'(127), DIR_DECRYPT);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h7E, 1'b1);
        settle_idle();

        // pressure: receiver holds off while a full message plus one dropped final
        // byte goes in, then a short message has to wait behind it
        set_config(RAILS_W'(5), DIR_DECRYPT);
        hold_req = 1'b1;
        send_random_message(MAX_MESSAGE_DEF + 1);
        send_random_message(4);
        settle_idle();

        // random phases, each with its own setting and idle pattern
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            set_idle_mode(phase);
            case ($urandom_range(7))
                0:       nrails = RAILS_W'(0);
                1:       nrails = RAILS_W'(1);
                2:       nrails = RAILS_W'(2);
                3:       nrails = RAILS_W'(64);
                4:       nrails = RAILS_W'(127);
                5:       nrails = RAILS_W'($urandom_range(127));
                default: nrails = RAILS_W'($urandom_range(2, 12));
            endcase
            set_config(nrails, logic'($urandom_range(1)));
            repeat ($urandom_range(3, 6)) begin
                if (items_sent < ITEM_TARGET) begin
                    // mostly short messages, now and then one near or past capacity
                    roll = $urandom_range(99);
                    if (roll < 85)      len = $urandom_range(1, 10);
                    else if (roll < 95) len = $urandom_range(11, 30);
                    else                len = $urandom_range(60, 72);
                    send_random_message(len);
                end
            end
            settle_idle();
            phase++;
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> rail_fence_transposer_unit.f
hw/rtl/rft_pkg.sv
hw/rtl/rft_if.sv
hw/rtl/rail_fence_transposer_unit.sv
tb/rft_permutation_check.sv
tb/testbench.sv
